// File: sv/twfg_pkg.sv
// Shared constants, codes, types and the quarter-wave sine table for the
// waveform field generator. No dependencies.
`default_nettype none
package twfg_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int PHASE_BITS       = 16;
   localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_QUARTER     = SINE_TABLE_DEPTH / 4;
   localparam int QUARTER_BITS     = SINE_BITS - 2;
   localparam int DIV_STEPS        = 32 + PHASE_BITS;
   localparam int DIV_CNT_BITS     = $clog2(DIV_STEPS + 1);

   localparam logic [31:0] DEFAULT_PERIOD = 32'd5000;
   localparam logic [31:0] SEED_BASE      = 32'd12345;
   localparam logic [31:0] SEED_STEP      = 32'd7919;
   localparam logic [18:0] OCT1_FACTOR    = 19'd177603;   // 2.71 in Q16
   localparam logic [18:0] OCT2_FACTOR    = 19'd478413;   // 7.3 in Q16
   localparam logic [15:0] WEIGHT0        = 16'd39322;    // 0.6
   localparam logic [15:0] WEIGHT1        = 16'd19661;    // 0.3
   localparam logic [15:0] WEIGHT2        = 16'd6554;     // 0.1
   localparam logic [15:0] JITTER_GAIN    = 16'd655;      // 1% of range

   // wave kinds
   localparam logic [2:0] WAVE_NONE   = 3'd0;
   localparam logic [2:0] WAVE_SINE   = 3'd1;
   localparam logic [2:0] WAVE_RAMP   = 3'd2;
   localparam logic [2:0] WAVE_SQUARE = 3'd3;
   localparam logic [2:0] WAVE_NOISE  = 3'd4;
   localparam logic [2:0] WAVE_CONST  = 3'd5;

   // field types
   localparam logic [2:0] TYPE_U8  = 3'd0;
   localparam logic [2:0] TYPE_S8  = 3'd1;
   localparam logic [2:0] TYPE_U16 = 3'd2;
   localparam logic [2:0] TYPE_S16 = 3'd3;
   localparam logic [2:0] TYPE_U32 = 3'd4;
   localparam logic [2:0] TYPE_S32 = 3'd5;
   localparam logic [2:0] TYPE_F32 = 3'd6;

   // register indexes
   localparam logic [2:0] CSR_WAVE_KIND   = 3'd0;
   localparam logic [2:0] CSR_MIN_VALUE   = 3'd1;
   localparam logic [2:0] CSR_MAX_VALUE   = 3'd2;
   localparam logic [2:0] CSR_PERIOD_MS   = 3'd3;
   localparam logic [2:0] CSR_INV_SCALE   = 3'd4;
   localparam logic [2:0] CSR_RAW_OFFSET  = 3'd5;
   localparam logic [2:0] CSR_OUT_TYPE    = 3'd6;
   localparam logic [2:0] CSR_FIELD_INDEX = 3'd7;

   // controller states, also the datapath step code
   typedef logic [4:0] step_type;
   localparam step_type ST_IDLE  = 5'd0;
   localparam step_type ST_DIV   = 5'd1;
   localparam step_type ST_ANG1  = 5'd2;
   localparam step_type ST_ANG2  = 5'd3;
   localparam step_type ST_ANG3  = 5'd4;
   localparam step_type ST_WAV0  = 5'd5;
   localparam step_type ST_WAV1  = 5'd6;
   localparam step_type ST_WAV2  = 5'd7;
   localparam step_type ST_WAV3  = 5'd8;
   localparam step_type ST_JIT1  = 5'd9;
   localparam step_type ST_JIT2  = 5'd10;
   localparam step_type ST_HALF  = 5'd11;
   localparam step_type ST_RAMP  = 5'd12;
   localparam step_type ST_DISP  = 5'd13;
   localparam step_type ST_SCALE = 5'd14;
   localparam step_type ST_RQ    = 5'd15;
   localparam step_type ST_NORM  = 5'd16;
   localparam step_type ST_OUT   = 5'd17;
   localparam step_type ST_SEED  = 5'd18;
   localparam step_type ST_DRAW0 = 5'd19;
   localparam step_type ST_DRAW1 = 5'd20;
   localparam step_type ST_DRAW2 = 5'd21;

   typedef struct packed {
      step_type step;
      logic     start;      // request taken this cycle
      logic     rsp_load;   // load output register
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic norm_done;
   } dp_status_type;

   // Quarter wave: entry k-1 holds sin(k/quarter * pi/2) in Q16, k = 1..quarter.
   typedef logic [16:0] sine_rom_type [SINE_QUARTER];

   localparam longint TWO30 = 64'sd1073741824;

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint u, x2, acc, s;
      for (int k = 1; k <= SINE_QUARTER; k++) begin
         u   = (longint'(k) <<< 30) / SINE_QUARTER;
         x2  = (u * u) / TWO30;
         acc = -64'sd3864;
         acc = 64'sd172272     + (acc * x2) / TWO30;
         acc = -64'sd5026995   + (acc * x2) / TWO30;
         acc = 64'sd85569306   + (acc * x2) / TWO30;
         acc = -64'sd693598668 + (acc * x2) / TWO30;
         acc = 64'sd1686629713 + (acc * x2) / TWO30;
         s   = (acc * u) / TWO30;
         if (s < 0) s = 0;
         s = (s + 8192) / 16384;
         if (s > 65536) s = 65536;
         rom[k-1] = 17'(s);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

// File: sv/twfg_ctrl.sv
// Sequencer for the waveform field generator: walks the datapath steps and
// owns the stream handshakes. Depends on twfg_pkg.
`default_nettype none
module twfg_ctrl import twfg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tuser,     // op: init when high
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   step_type state_ff, state_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     load;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign load       = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = req_tuser ? ST_SEED : ST_DIV;
         ST_DIV:   if (status.div_done) state_in = ST_ANG1;
         ST_ANG1:  state_in = ST_ANG2;
         ST_ANG2:  state_in = ST_ANG3;
         ST_ANG3:  state_in = ST_WAV0;
         ST_WAV0:  state_in = ST_WAV1;
         ST_WAV1:  state_in = ST_WAV2;
         ST_WAV2:  state_in = ST_WAV3;
         ST_WAV3:  state_in = ST_JIT1;
         ST_JIT1:  state_in = ST_JIT2;
         ST_JIT2:  state_in = ST_HALF;
         ST_HALF:  state_in = ST_RAMP;
         ST_RAMP:  state_in = ST_DISP;
         ST_DISP:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_RQ;
         ST_RQ:    state_in = ST_NORM;
         ST_NORM:  if (status.norm_done) state_in = ST_OUT;
         ST_OUT:   if (load) state_in = ST_IDLE;
         ST_SEED:  state_in = ST_DRAW0;
         ST_DRAW0: state_in = ST_DRAW1;
         ST_DRAW1: state_in = ST_DRAW2;
         ST_DRAW2: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load)            rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_comb begin
      cmd.step     = state_ff;
      cmd.start    = (state_ff == ST_IDLE) && req_tvalid;
      cmd.rsp_load = load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/twfg_dp.sv
// Datapath of the waveform field generator: registers, phase divider, shared
// multiplier, sine lookup, noise generator, scaling and float packing.
// Depends on twfg_pkg.
`default_nettype none
module twfg_dp import twfg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [31:0]   tick_ms,
   input  logic          csr_wr_en,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   output logic [31:0]   display_value,
   output logic [31:0]   raw_bits,
   output logic [2:0]    byte_count
);

   function automatic logic signed [17:0] sine_at(input logic [31:0] angle);
      logic [SINE_BITS-1:0]    idx;
      logic [1:0]              quad;
      logic [QUARTER_BITS-1:0] j;
      logic [QUARTER_BITS:0]   k;
      logic [QUARTER_BITS:0]   km1;
      logic [16:0]             mag;
      idx  = angle[31 -: SINE_BITS];
      quad = idx[SINE_BITS-1 -: 2];
      j    = idx[QUARTER_BITS-1:0];
      k    = quad[0] ? ((QUARTER_BITS+1)'(SINE_QUARTER) - {1'b0, j}) : {1'b0, j};
      km1  = k - 1'b1;
      mag  = (k == '0) ? 17'd0 : SINE_ROM[km1[QUARTER_BITS-1:0]];
      return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   // signed divide by 2^sh, truncating toward zero
   function automatic logic signed [67:0] trunc_pow2(input logic signed [67:0] v,
                                                      input int sh);
      logic signed [67:0] bias;
      bias = v[67] ? ((68'sd1 <<< sh) - 68'sd1) : 68'sd0;
      return (v + bias) >>> sh;
   endfunction

   function automatic logic [31:0] xorshift(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x << 13);
      y = y ^ (y >> 17);
      y = y ^ (y << 5);
      return y;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sh07FFFFFFF)       return 32'sh7FFFFFFF;
      else if (v < -36'sh080000000) return -32'sh80000000;
      else                          return v[31:0];
   endfunction

   // configuration
   logic [2:0]  wave_kind_ff, wave_kind_in;
   logic [31:0] min_ff, min_in, max_ff, max_in, period_ff, period_in;
   logic [31:0] inv_ff, inv_in, off_ff, off_in;
   logic [2:0]  type_ff, type_in;
   logic [7:0]  fidx_ff, fidx_in;

   // generator state
   logic [31:0] seed_ff, seed_in;
   logic [15:0] oct0_ff, oct0_in, oct1_ff, oct1_in, oct2_ff, oct2_in;

   // work registers
   logic [31:0]             dvd_ff, dvd_in, rem_ff, rem_in;
   logic [PHASE_BITS-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [31:0]             a0_ff, a0_in, a1_ff, a1_in, a2_ff, a2_in;
   logic signed [17:0]      sin_ff, sin_in;
   logic signed [67:0]      prod_ff, prod_in;
   logic signed [39:0]      acc_ff, acc_in;
   logic signed [18:0]      w_ff, w_in;
   logic signed [33:0]      jr_ff, jr_in, j_ff, j_in, hw_ff, hw_in;
   logic signed [31:0]      disp_ff, disp_in;
   logic signed [63:0]      rq_ff, rq_in;
   logic [63:0]             norm_ff, norm_in;
   logic [5:0]              shamt_ff, shamt_in;
   logic                    sign_ff, sign_in;
   logic [31:0]             out_disp_ff, out_bits_ff;
   logic [2:0]              out_cnt_ff;

   // combinational helpers
   logic [31:0]        per_eff, t, r_next;
   logic [32:0]        trial;
   logic               ge;
   logic signed [33:0] mn, mx, range, sum, mid, half;
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] tr_a, tr_b;
   logic signed [35:0] s_ramp, s_sine, s_noise, s_clamp;
   logic signed [31:0] disp_sel;
   logic signed [63:0] rq_calc, rq_bias, rq_adj;
   logic signed [31:0] raw;
   logic [23:0]        mant;
   logic               rnd;
   logic [24:0]        m25;
   logic [7:0]         expo;
   logic [31:0]        f32_bits, bits_sel;
   logic [2:0]         cnt_sel;

   assign per_eff = (period_ff == '0) ? DEFAULT_PERIOD : period_ff;
   assign t       = {quo_ff, {(32-PHASE_BITS){1'b0}}};
   assign trial   = {rem_ff, dvd_ff[31]};
   assign ge      = trial >= {1'b0, per_eff};
   assign r_next  = xorshift(seed_ff);

   assign mn    = 34'($signed(min_ff));
   assign mx    = 34'($signed(max_ff));
   assign range = mx - mn;
   assign sum   = mn + mx;
   assign mid   = (sum + $signed({33'b0, sum[33]})) >>> 1;
   assign half  = (range + $signed({33'b0, range[33]})) >>> 1;

   assign status.div_done  = (cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1));
   assign status.norm_done = norm_ff[63] || (norm_ff == '0);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.step)
         ST_ANG1:  begin mul_a = $signed({2'b0, t}); mul_b = 34'(OCT1_FACTOR); end
         ST_ANG2:  begin mul_a = $signed({2'b0, t}); mul_b = 34'(OCT2_FACTOR); end
         ST_WAV0:  begin mul_a = 34'(WEIGHT0); mul_b = 34'(sin_ff); end
         ST_WAV1:  begin mul_a = 34'(WEIGHT1); mul_b = 34'(sin_ff); end
         ST_WAV2:  begin mul_a = 34'(WEIGHT2); mul_b = 34'(sin_ff); end
         ST_WAV3:  begin mul_a = range; mul_b = 34'(JITTER_GAIN); end
         ST_JIT2:  begin mul_a = jr_ff; mul_b = 34'($signed(seed_ff)); end
         ST_HALF:  begin
            mul_a = half;
            mul_b = (wave_kind_ff == WAVE_SINE) ? 34'(sin_ff) : 34'(w_ff);
         end
         ST_RAMP:  begin mul_a = range; mul_b = $signed(34'({1'b0, quo_ff})); end
         ST_SCALE: begin mul_a = 34'(disp_ff); mul_b = 34'($signed(inv_ff)); end
         default:  ;
      endcase
   end

   // display value for each kind
   always_comb begin
      tr_a    = trunc_pow2(prod_ff, PHASE_BITS);
      s_ramp  = 36'(mn) + $signed(tr_a[35:0]);
      s_sine  = 36'(mid) + 36'(hw_ff);
      s_noise = s_sine + 36'(j_ff);
      s_clamp = (s_noise < 36'(mn)) ? 36'(mn) : s_noise;
      if (s_clamp > 36'(mx)) s_clamp = 36'(mx);
      unique case (wave_kind_ff)
         WAVE_SINE:   disp_sel = sat32(s_sine);
         WAVE_RAMP:   disp_sel = sat32(s_ramp);
         WAVE_SQUARE: disp_sel = quo_ff[PHASE_BITS-1] ? min_ff : max_ff;
         WAVE_NOISE:  disp_sel = sat32(s_clamp);
         WAVE_CONST:  disp_sel = min_ff;
         default:     disp_sel = sat32(36'(mid));
      endcase
   end

   // raw value, field saturation, float packing
   always_comb begin
      rq_calc  = (inv_ff == '0) ? 64'sd0
               : $signed(prod_ff[63:0]) - $signed({{16{off_ff[31]}}, off_ff, 16'b0});
      rq_bias  = rq_ff[63] ? 64'sd4294967295 : 64'sd0;
      rq_adj   = rq_ff + rq_bias;
      raw      = $signed(rq_adj[63:32]);
      mant     = norm_ff[63:40];
      rnd      = norm_ff[39] && ((|norm_ff[38:0]) || mant[0]);
      m25      = {1'b0, mant} + {24'b0, rnd};
      expo     = 8'd158 - {2'b0, shamt_ff} + {7'b0, m25[24]};
      f32_bits = (norm_ff == '0) ? 32'd0
               : {sign_ff, expo, (m25[24] ? 23'd0 : m25[22:0])};
      bits_sel = '0;
      cnt_sel  = 3'd0;
      unique case (type_ff)
         TYPE_U8: begin
            bits_sel = raw[31] ? 32'd0 : ((raw > 32'sd255) ? 32'd255 : raw);
            cnt_sel  = 3'd1;
         end
         TYPE_S8: begin
            bits_sel = (raw > 32'sd127) ? 32'd127
                     : ((raw < -32'sd128) ? 32'h80 : {24'b0, raw[7:0]});
            cnt_sel  = 3'd1;
         end
         TYPE_U16: begin
            bits_sel = raw[31] ? 32'd0 : ((raw > 32'sd65535) ? 32'd65535 : raw);
            cnt_sel  = 3'd2;
         end
         TYPE_S16: begin
            bits_sel = (raw > 32'sd32767) ? 32'd32767
                     : ((raw < -32'sd32768) ? 32'h8000 : {16'b0, raw[15:0]});
            cnt_sel  = 3'd2;
         end
         TYPE_U32: begin
            bits_sel = raw[31] ? 32'd0 : raw;
            cnt_sel  = 3'd4;
         end
         TYPE_S32: begin
            bits_sel = raw;
            cnt_sel  = 3'd4;
         end
         TYPE_F32: begin
            bits_sel = f32_bits;
            cnt_sel  = 3'd4;
         end
         default: ;
      endcase
   end

   // configuration writes
   always_comb begin
      wave_kind_in = wave_kind_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      period_in    = period_ff;
      inv_in       = inv_ff;
      off_in       = off_ff;
      type_in      = type_ff;
      fidx_in      = fidx_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WAVE_KIND:   wave_kind_in = csr_wdata[2:0];
            CSR_MIN_VALUE:   min_in       = csr_wdata;
            CSR_MAX_VALUE:   max_in       = csr_wdata;
            CSR_PERIOD_MS:   period_in    = csr_wdata;
            CSR_INV_SCALE:   inv_in       = csr_wdata;
            CSR_RAW_OFFSET:  off_in       = csr_wdata;
            CSR_OUT_TYPE:    type_in      = csr_wdata[2:0];
            CSR_FIELD_INDEX: fidx_in      = csr_wdata[7:0];
         endcase
      end
   end

   // step actions
   always_comb begin
      seed_in  = seed_ff;
      oct0_in  = oct0_ff;
      oct1_in  = oct1_ff;
      oct2_in  = oct2_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      a0_in    = a0_ff;
      a1_in    = a1_ff;
      a2_in    = a2_ff;
      sin_in   = sin_ff;
      prod_in  = mul_a * mul_b;
      acc_in   = acc_ff;
      w_in     = w_ff;
      jr_in    = jr_ff;
      j_in     = j_ff;
      hw_in    = hw_ff;
      disp_in  = disp_ff;
      rq_in    = rq_ff;
      norm_in  = norm_ff;
      shamt_in = shamt_ff;
      sign_in  = sign_ff;
      tr_b     = '0;
      unique case (cmd.step)
         ST_IDLE: if (cmd.start) begin
            dvd_in = tick_ms;
            rem_in = '0;
            cnt_in = '0;
         end
         ST_DIV: begin
            rem_in = ge ? 32'(trial - {1'b0, per_eff}) : trial[31:0];
            quo_in = {quo_ff[PHASE_BITS-2:0], ge};
            dvd_in = {dvd_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_ANG1: a0_in = t + {oct0_ff, 16'b0};
         ST_ANG2: a1_in = prod_ff[47:16] + {oct1_ff, 16'b0};
         ST_ANG3: begin
            a2_in  = prod_ff[47:16] + {oct2_ff, 16'b0};
            sin_in = sine_at(a0_ff);
         end
         ST_WAV0: sin_in = sine_at(a1_ff);
         ST_WAV1: begin
            acc_in = 40'(prod_ff);
            sin_in = sine_at(a2_ff);
         end
         ST_WAV2: acc_in = acc_ff + 40'(prod_ff);
         ST_WAV3: begin
            tr_b   = trunc_pow2(68'(acc_ff) + prod_ff, 16);
            w_in   = tr_b[18:0];
            sin_in = sine_at(t);
         end
         ST_JIT1: begin
            tr_b  = trunc_pow2(prod_ff, 16);
            jr_in = tr_b[33:0];
            if (wave_kind_ff == WAVE_NOISE) seed_in = r_next;
         end
         ST_HALF: begin
            tr_b = trunc_pow2(prod_ff, 31);
            j_in = tr_b[33:0];
         end
         ST_RAMP: begin
            tr_b  = trunc_pow2(prod_ff, 16);
            hw_in = tr_b[33:0];
         end
         ST_DISP: disp_in = disp_sel;
         ST_RQ: begin
            rq_in    = rq_calc;
            sign_in  = rq_calc[63];
            norm_in  = rq_calc[63] ? 64'(-rq_calc) : 64'(rq_calc);
            shamt_in = '0;
         end
         ST_NORM: if (!status.norm_done) begin
            if (norm_ff[63:56] == '0) begin
               norm_in  = {norm_ff[55:0], 8'b0};
               shamt_in = shamt_ff + 6'd8;
            end else begin
               norm_in  = {norm_ff[62:0], 1'b0};
               shamt_in = shamt_ff + 6'd1;
            end
         end
         ST_SEED: seed_in = SEED_BASE + 32'(fidx_ff) * SEED_STEP;
         ST_DRAW0: begin
            seed_in = r_next;
            oct0_in = {~r_next[31], r_next[30:16]};
         end
         ST_DRAW1: begin
            seed_in = r_next;
            oct1_in = {~r_next[31], r_next[30:16]};
         end
         ST_DRAW2: begin
            seed_in = r_next;
            oct2_in = {~r_next[31], r_next[30:16]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_kind_ff <= WAVE_NONE;
         min_ff       <= '0;
         max_ff       <= '0;
         period_ff    <= DEFAULT_PERIOD;
         inv_ff       <= 32'd65536;
         off_ff       <= '0;
         type_ff      <= TYPE_U8;
         fidx_ff      <= '0;
         seed_ff      <= SEED_BASE;
         oct0_ff      <= '0;
         oct1_ff      <= '0;
         oct2_ff      <= '0;
      end else begin
         wave_kind_ff <= wave_kind_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         period_ff    <= period_in;
         inv_ff       <= inv_in;
         off_ff       <= off_in;
         type_ff      <= type_in;
         fidx_ff      <= fidx_in;
         seed_ff      <= seed_in;
         oct0_ff      <= oct0_in;
         oct1_ff      <= oct1_in;
         oct2_ff      <= oct2_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      a0_ff    <= a0_in;
      a1_ff    <= a1_in;
      a2_ff    <= a2_in;
      sin_ff   <= sin_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      w_ff     <= w_in;
      jr_ff    <= jr_in;
      j_ff     <= j_in;
      hw_ff    <= hw_in;
      disp_ff  <= disp_in;
      rq_ff    <= rq_in;
      norm_ff  <= norm_in;
      shamt_ff <= shamt_in;
      sign_ff  <= sign_in;
      if (cmd.rsp_load) begin
         out_disp_ff <= (wave_kind_ff == WAVE_NONE) ? 32'd0 : disp_ff;
         out_bits_ff <= (wave_kind_ff == WAVE_NONE) ? 32'd0 : bits_sel;
         out_cnt_ff  <= (wave_kind_ff == WAVE_NONE) ? 3'd0 : cnt_sel;
      end
   end

   assign display_value = out_disp_ff;
   assign raw_bits      = out_bits_ff;
   assign byte_count    = out_cnt_ff;

endmodule
`default_nettype wire

// File: sv/test_waveform_field_generator.sv
// Waveform field generator: one log field value (sine, ramp, square, noise,
// constant) per tick request, scaled and saturated to the field type.
// A tick result passes 48 divider steps, 14 fixed steps and 1 to 15 normalize
// steps (size of the scaled value) before the output step.
// One request in flight; an init request walks the seed and draw steps, no result.
// Reset (synchronous, active high) restores register defaults and the seed.
`default_nettype none
module test_waveform_field_generator import twfg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] tick_ms
   input  logic        req_tuser,   // [0] op: 0 tick, 1 init
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] display_value, [63:32] raw_bits,
                                    // [66:64] byte_count, rest zero
   // register write port
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [31:0]   display_value, raw_bits;
   logic [2:0]    byte_count;

   // Controller walks the steps; the result waits in the output register so a
   // new request can start while the previous result is still unclaimed.
   twfg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: phase = tick * 2^16 / period (low 16 quotient bits), shared
   // 34x34 multiplier, quarter-wave sine table, xorshift noise, scaling.
   twfg_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .tick_ms       (req_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .display_value (display_value),
      .raw_bits      (raw_bits),
      .byte_count    (byte_count)
   );

   assign rsp_tdata = {5'b0, byte_count, raw_bits, display_value};

   // only one request in flight
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // byte count is at most four
   a_byte_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[66:64] <= 3'd4))
      else $error("byte count out of range");

   // an empty field carries no raw bits
   a_empty_field: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[66:64] == 3'd0) |-> (rsp_tdata[63:32] == 32'd0))
      else $error("raw bits set with zero byte count");

   // the output register loads only when it is free or being drained
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before delivery");

endmodule
`default_nettype wire

// File: sim/test_waveform_field_generator_tb.sv
// Self-checking testbench for the waveform field generator: random and directed
// tick/init requests, a built-in value predictor and a streaming scoreboard.
// Depends on twfg_pkg and test_waveform_field_generator.
`timescale 1ns / 100ps
`default_nettype none
module test_waveform_field_generator_tb;
   import twfg_pkg::*;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_INIT = 1'b1;
   localparam int   STALL_LIMIT = 5000;   // cycles with no handshake or register write
   localparam int   SETTLE_CYCLES = 100;  // > worst tick latency
   localparam int   HOLD_CYCLES = 600;    // long receiver hold-off

   typedef struct {
      logic        op;
      logic [31:0] tick_ms;
   } field_req_type;

   typedef struct {
      logic [31:0] display;
      logic [31:0] raw_bits;
      logic [2:0]  byte_count;
   } field_val_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   test_waveform_field_generator i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the block's registers and generator state
   logic [2:0]  m_wave, m_type;
   logic [31:0] m_min, m_max, m_period, m_inv, m_offset;
   logic [7:0]  m_field;
   logic [31:0] m_seed = SEED_BASE;
   logic [15:0] m_oct [3] = '{default: '0};
   longint      sine_tab [SINE_TABLE_DEPTH];

   field_req_type pending_reqs [$];
   field_val_type expected_vals [$];
   int          req_queued = 0, req_accepted = 0;
   int          ticks_sent = 0, inits_sent = 0, vals_checked = 0, errors = 0;
   int          send_idle_pct = 0, recv_idle_pct = 0;
   int          hold_cycles = 0;
   logic        hold_go = 1'b0;
   logic        hold_seen = 1'b0;
   logic        req_fire = 1'b0;
   int          quiet_cycles = 0;

   // directed sine ticks: quarter points of the default period, its last tick and the top value
   logic [31:0] p_list [6] = '{32'd0, 32'd1250, 32'd2500, 32'd3750, 32'd4999,
                               32'hFFFF_FFFF};

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------- predictor ----------------

   // sine table entry in Q16, integer Taylor polynomial on a quarter wave
   function automatic longint sine_point(int i);
      longint cf [6];
      longint a, u, x2, acc, s;
      int quad;
      cf = '{64'sd1686629713, -64'sd693598668, 64'sd85569306,
             -64'sd5026995, 64'sd172272, -64'sd3864};
      a = (longint'(i) <<< 32) / SINE_TABLE_DEPTH;
      quad = int'((a >>> 30) & 3);
      u = a & 64'h3FFF_FFFF;
      if (quad & 1) u = (64'sd1 <<< 30) - u;
      x2 = (u * u) / (64'sd1 <<< 30);
      acc = cf[5];
      for (int k = 4; k >= 0; k--) acc = cf[k] + (acc * x2) / (64'sd1 <<< 30);
      s = (acc * u) / (64'sd1 <<< 30);
      if (s < 0) s = 0;
      s = (s + 8192) / 16384;
      if (s > 65536) s = 65536;
      return (quad & 2) ? -s : s;
   endfunction

   function automatic longint sine_of(logic [31:0] angle);
      logic [63:0] idx;
      idx = (64'(angle) * SINE_TABLE_DEPTH) >> 32;
      return sine_tab[idx];
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [31:0] xorshift_next();
      logic [31:0] x;
      x = m_seed;
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      m_seed = x;
      return x;
   endfunction

   // Q32 fixed value to float32, round to nearest even
   function automatic logic [31:0] q32_to_float(longint v);
      logic [31:0] sgn;
      logic [63:0] m, mant, rem, hf;
      int p, sh;
      if (v == 0) return 32'd0;
      sgn = (v < 0) ? 32'h8000_0000 : 32'd0;
      m = (v < 0) ? 64'(-v) : 64'(v);
      p = 63;
      while (!m[p]) p--;
      if (p > 23) begin
         sh = p - 23;
         rem = m & ((64'd1 << sh) - 1);
         hf = 64'd1 << (sh - 1);
         mant = m >> sh;
         if (rem > hf || (rem == hf && mant[0])) mant++;
         if (mant == (64'd1 << 24)) begin
            mant >>= 1;
            p++;
         end
      end else begin
         mant = m << (23 - p);
      end
      return sgn | (32'(p - 32 + 127) << 23) | 32'(mant & 64'h7F_FFFF);
   endfunction

   function automatic void reseed_field();
      m_seed = SEED_BASE + 32'(m_field) * SEED_STEP;
      for (int k = 0; k < 3; k++) m_oct[k] = 16'((xorshift_next() ^ 32'h8000_0000) >> 16);
   endfunction

   function automatic field_val_type field_value_at(logic [31:0] tick);
      field_val_type r;
      longint mn, mx, rng, mid, half, disp, rq, raw, w, jit;
      logic [63:0] per, ph;
      logic [31:0] t, a1, a2;
      mn = longint'($signed(m_min));
      mx = longint'($signed(m_max));
      rng = mx - mn;
      mid = (mn + mx) / 2;
      half = rng / 2;
      r = '{32'd0, 32'd0, 3'd0};
      if (m_wave == WAVE_NONE) return r;
      per = (m_period != 0) ? 64'(m_period) : 64'(DEFAULT_PERIOD);
      ph = ((64'(tick) % per) << PHASE_BITS) / per;
      t = 32'(ph << (32 - PHASE_BITS));
      case (m_wave)
         WAVE_SINE:   disp = mid + (half * sine_of(t)) / 65536;
         WAVE_RAMP:   disp = mn + (rng * longint'(ph)) / (64'sd1 <<< PHASE_BITS);
         WAVE_SQUARE: disp = (ph < (64'd1 << (PHASE_BITS - 1))) ? mx : mn;
         WAVE_NOISE: begin
            a1 = 32'((64'(t) * 64'(OCT1_FACTOR)) >> 16);
            a2 = 32'((64'(t) * 64'(OCT2_FACTOR)) >> 16);
            w = (longint'(WEIGHT0) * sine_of(t + {m_oct[0], 16'd0})
               + longint'(WEIGHT1) * sine_of(a1 + {m_oct[1], 16'd0})
               + longint'(WEIGHT2) * sine_of(a2 + {m_oct[2], 16'd0})) / 65536;
            jit = ((rng * longint'(JITTER_GAIN)) / 65536)
                  * longint'($signed(xorshift_next())) / 64'sd2147483648;
            disp = mid + (half * w) / 65536 + jit;
            if (disp < mn) disp = mn;
            if (disp > mx) disp = mx;
         end
         WAVE_CONST:  disp = mn;
         default:     disp = mid;   // undefined kinds fall back to midpoint
      endcase
      disp = clip(disp, -64'sd2147483648, 64'sd2147483647);
      rq = (m_inv == 0) ? 0
           : disp * longint'($signed(m_inv)) - longint'($signed(m_offset)) * 65536;
      raw = rq / 64'sd4294967296;
      case (m_type)
         TYPE_U8:  begin r.raw_bits = 32'(clip(raw, 0, 255)); r.byte_count = 1; end
         TYPE_S8:  begin r.raw_bits = 32'(clip(raw, -128, 127)) & 32'hFF; r.byte_count = 1; end
         TYPE_U16: begin r.raw_bits = 32'(clip(raw, 0, 65535)); r.byte_count = 2; end
         TYPE_S16: begin
            r.raw_bits = 32'(clip(raw, -32768, 32767)) & 32'hFFFF;
            r.byte_count = 2;
         end
         TYPE_U32: begin r.raw_bits = 32'(clip(raw, 0, 64'sd4294967295)); r.byte_count = 4; end
         TYPE_S32: begin
            r.raw_bits = 32'(clip(raw, -64'sd2147483648, 64'sd2147483647));
            r.byte_count = 4;
         end
         TYPE_F32: begin r.raw_bits = q32_to_float(rq); r.byte_count = 4; end
         default: ;   // unknown type writes nothing
      endcase
      r.display = 32'(disp);
      return r;
   endfunction

   // ---------------- request driver ----------------

   always @(posedge clock) req_fire <= req_tvalid && req_tready;

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fire)) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_reqs[0].op;
            req_tdata  <= pending_reqs[0].tick_ms;
            void'(pending_reqs.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result-side ready, with one long hold-off to back up the block
   always @(negedge clock) begin
      if (hold_go && !hold_seen) begin
         hold_seen   <= 1'b1;
         hold_cycles <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------- monitors ----------------

   // prediction happens at acceptance; registers never change mid-phase
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         req_accepted++;
         if (req_tuser == OP_INIT) begin
            reseed_field();
            inits_sent++;
         end else begin
            expected_vals.push_back(field_value_at(req_tdata));
            ticks_sent++;
         end
      end
   end

   always @(posedge clock) begin
      field_val_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_vals.size() == 0) begin
            $display("%0t: unexpected result, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_vals.pop_front();
            vals_checked++;
            if (rsp_tdata[31:0] !== want.display) begin
               $display("%0t: display_value expected %h actual %h",
                        $time, want.display, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== want.raw_bits) begin
               $display("%0t: raw_bits expected %h actual %h",
                        $time, want.raw_bits, rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tdata[66:64] !== want.byte_count) begin
               $display("%0t: byte_count expected %0d actual %0d",
                        $time, want.byte_count, rsp_tdata[66:64]);
               errors++;
            end
            if (rsp_tdata[71:67] !== 5'd0) begin
               $display("%0t: padding expected 0 actual %h", $time, rsp_tdata[71:67]);
               errors++;
            end
         end
      end
   end

   // watchdog: any handshake on either channel or the register port is progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------- sequencing ----------------

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_WAVE_KIND:   m_wave   = val[2:0];
         CSR_MIN_VALUE:   m_min    = val;
         CSR_MAX_VALUE:   m_max    = val;
         CSR_PERIOD_MS:   m_period = val;
         CSR_INV_SCALE:   m_inv    = val;
         CSR_RAW_OFFSET:  m_offset = val;
         CSR_OUT_TYPE:    m_type   = val[2:0];
         CSR_FIELD_INDEX: m_field  = val[7:0];
         default: ;
      endcase
   endtask

   task automatic program_field(logic [2:0] wave, logic [31:0] mn, logic [31:0] mx,
                                logic [31:0] per, logic [31:0] inv, logic [31:0] off,
                                logic [2:0] ftype, logic [7:0] fidx);
      csr_write(CSR_WAVE_KIND, 32'(wave));
      csr_write(CSR_MIN_VALUE, mn);
      csr_write(CSR_MAX_VALUE, mx);
      csr_write(CSR_PERIOD_MS, per);
      csr_write(CSR_INV_SCALE, inv);
      csr_write(CSR_RAW_OFFSET, off);
      csr_write(CSR_OUT_TYPE, 32'(ftype));
      csr_write(CSR_FIELD_INDEX, 32'(fidx));
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic push_req(logic op, logic [31:0] tick);
      field_req_type it;
      it.op = op;
      it.tick_ms = tick;
      pending_reqs.push_back(it);
      req_queued++;
   endtask

   // wait until every request is in and every value is out, then let inits finish
   task automatic drain();
      while (req_accepted != req_queued || expected_vals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_bound();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(200 << 16)) - 32'(100 << 16);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_period();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(1, 20));
         3: return 32'($urandom_range(100, 10000));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_inv();
      case ($urandom_range(4))
         0: return 32'd0;
         1: return 32'd65536;
         2: return 32'($urandom_range(1, 1 << 20)) * (($urandom_range(1)) ? 1 : -1);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int mode;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) sine_tab[i] = sine_point(i);
      m_wave = WAVE_NONE; m_min = 0; m_max = 0; m_period = DEFAULT_PERIOD;
      m_inv = 32'd65536; m_offset = 0; m_type = TYPE_U8; m_field = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset defaults (wave none), then each kind at the extremes
      push_req(OP_TICK, 32'd0);
      push_req(OP_TICK, 32'hFFFF_FFFF);
      drain();
      program_field(WAVE_SINE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF,
                    32'h8000_0000, TYPE_S32, 8'd255);
      foreach (p_list[i]) push_req(OP_TICK, p_list[i]);
      drain();
      program_field(WAVE_RAMP, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, TYPE_F32, 8'd0);
      push_req(OP_TICK, 32'hFFFF_FFFE);
      push_req(OP_TICK, 32'h7FFF_FFFF);
      drain();
      // noise with max below min, clamp lands on max
      program_field(WAVE_NOISE, 32'h0010_0000, 32'hFFF0_0000, 32'd1000, 32'd0,
                    32'd12345, TYPE_U16, 8'd7);
      push_req(OP_INIT, 32'd0);
      push_req(OP_TICK, 32'd250);
      push_req(OP_TICK, 32'd999);
      drain();
      program_field(WAVE_SQUARE, 32'hFFF0_0000, 32'h00FF_0000, 32'd2, 32'd65536,
                    32'd0, TYPE_U8, 8'd1);
      push_req(OP_TICK, 32'd0);
      push_req(OP_TICK, 32'd1);
      drain();
      // undefined wave kind and undefined field type
      program_field(3'd7, 32'h0001_0000, 32'h0003_0000, 32'd5000, 32'd65536,
                    32'd0, 3'd7, 8'd2);
      push_req(OP_TICK, 32'd42);
      drain();
      program_field(3'd6, 32'hFF00_0000, 32'h0100_0000, 32'd5000, 32'h0100_0000,
                    32'd0, TYPE_S8, 8'd3);
      push_req(OP_TICK, 32'd42);
      drain();
      program_field(WAVE_CONST, 32'hFFFE_0000, 32'd0, 32'd5000, 32'd65536,
                    32'h0000_8000, TYPE_U32, 8'd4);
      push_req(OP_TICK, 32'd1);
      drain();
      program_field(WAVE_CONST, 32'h8000_0000, 32'd0, 32'd5000, 32'h7FFF_FFFF,
                    32'd0, TYPE_S16, 8'd5);
      push_req(OP_TICK, 32'd1);
      drain();

      // random phases: idling mode rotates 30/81, 81/30, then none
      for (int ph_i = 0; ph_i < 12; ph_i++) begin
         mode = ph_i / 4;
         send_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 81 : 0;
         recv_idle_pct = (mode == 0) ? 81 : (mode == 1) ? 30 : 0;
         program_field(($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                                : 3'($urandom_range(1, 5)),
                       pick_bound(), pick_bound(), pick_period(), pick_inv(),
                       ($urandom_range(2) == 0) ? 32'd0 : $urandom,
                       3'($urandom_range(7)), 8'($urandom));
         if (m_wave == WAVE_NOISE || $urandom_range(1)) push_req(OP_INIT, 32'd0);
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(19) == 0)
               push_req(OP_INIT, $urandom);
            else if ($urandom_range(2) == 0)
               push_req(OP_TICK, 32'($urandom_range(20000)));
            else
               push_req(OP_TICK, $urandom);
         end
         // long receiver hold-off while requests keep coming
         if (ph_i == 9) hold_go = 1'b1;
         drain();
      end

      $display("Covered %0d ticks and %0d inits over all wave kinds and field types;",
               ticks_sent, inits_sent);
      $display("%0d values checked, %0d mismatches.", vals_checked, errors);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
